// ----- design/pafk_pkg.sv -----
// shared constants, types and the arctangent table for the planar arm
// forward kinematics block; no dependencies
`timescale 1ns / 1ps

package pafk_pkg;

   // field widths
   localparam int LEN_W    = 16;
   localparam int ANGLE_W  = 16;
   localparam int COORD_W  = 22;
   localparam int LINK_W   = 6;

   // arm and rotator sizing
   localparam int MAX_LINKS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                 : ATAN_ENTRIES;
   localparam int SHIFT_W       = $clog2(ATAN_ENTRIES);

   // rotator datapath: Q8.24 coordinates, residual angle in 2^-32 turn
   localparam int DATA_W    = 34;
   localparam int FRAC_DROP = 16;
   localparam int PROD_W    = LEN_W + 32;
   localparam int DELTA_W   = DATA_W - FRAC_DROP;

   // 1/K in Q0.32, applied to the length before rotation
   localparam logic [31:0] INV_GAIN = 32'd2608131496;
   localparam logic [PROD_W-1:0] PROD_ROUND = PROD_W'(32768);
   localparam logic signed [DATA_W-1:0] DATA_ROUND = DATA_W'(32768);

   // binary angle landmarks
   localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 16'h4000;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 16'h8000;
   localparam logic [ANGLE_W-1:0] ANGLE_3QUART  = 16'hC000;

   // coordinate limits
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // highest link index reported
   localparam logic [LINK_W-1:0] LINK_LAST = LINK_W'(MAX_LINKS - 1);

   // transaction traveling down the rotator chain
   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic [LINK_W-1:0]        link_num;
      logic                     last;
   } cordic_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [DATA_W-1:0] atan_step(input logic [SHIFT_W-1:0] idx);
      logic signed [DATA_W-1:0] val;
      case (idx)
         5'd0:    val = DATA_W'(536870912);
         5'd1:    val = DATA_W'(316933406);
         5'd2:    val = DATA_W'(167458907);
         5'd3:    val = DATA_W'(85004756);
         5'd4:    val = DATA_W'(42667331);
         5'd5:    val = DATA_W'(21354465);
         5'd6:    val = DATA_W'(10679838);
         5'd7:    val = DATA_W'(5340245);
         5'd8:    val = DATA_W'(2670163);
         5'd9:    val = DATA_W'(1335087);
         5'd10:   val = DATA_W'(667544);
         5'd11:   val = DATA_W'(333772);
         5'd12:   val = DATA_W'(166886);
         5'd13:   val = DATA_W'(83443);
         5'd14:   val = DATA_W'(41722);
         5'd15:   val = DATA_W'(20861);
         5'd16:   val = DATA_W'(10430);
         5'd17:   val = DATA_W'(5215);
         5'd18:   val = DATA_W'(2608);
         5'd19:   val = DATA_W'(1304);
         5'd20:   val = DATA_W'(652);
         5'd21:   val = DATA_W'(326);
         5'd22:   val = DATA_W'(163);
         5'd23:   val = DATA_W'(81);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/planar_arm_forward_kinematics.sv -----
// top level of the planar arm forward kinematics block: front end, a row
// of rotator cells and the accumulating back end; uses pafk_pkg and all pafk modules
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_ready   seg_length, joint_angle, last_link
//   rsp_      out         rsp_valid/rsp_ready   point_x, point_y, link_number,
//                                               is_end_effector
//
// one transaction per cycle sustained while rsp_ready holds high; the path is
// two front slots, one slot per cell (16 rotator cells) and the result register.
// only the angle sum and link count at the input and the position add at the output
// carry from one link to the next; each is a single add per cycle.
// synchronous reset empties every slot and puts the arm base at the origin.
// every slot holds its transaction under backpressure and a bubble anywhere
// in the row lets req_ready rise even while a result waits to be taken.
`timescale 1ns / 1ps

module planar_arm_forward_kinematics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pafk_pkg::LEN_W-1:0]          req_seg_length,
   input  logic [pafk_pkg::ANGLE_W-1:0]        req_joint_angle,
   input  logic                                req_last_link,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pafk_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [pafk_pkg::COORD_W-1:0] rsp_point_y,
   output logic [pafk_pkg::LINK_W-1:0]         rsp_link_number,
   output logic                                rsp_is_end_effector
);

   // links between slots: index 0 is the front end output
   logic                 chain_valid [pafk_pkg::NUM_CELLS+1];
   logic                 chain_ready [pafk_pkg::NUM_CELLS+1];
   pafk_pkg::cordic_type chain_data  [pafk_pkg::NUM_CELLS+1];

   // angle accumulation and start vector
   pafk_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_seg_length  (req_seg_length),
      .req_joint_angle (req_joint_angle),
      .req_last_link   (req_last_link),
      .out_valid       (chain_valid[0]),
      .out_ready       (chain_ready[0]),
      .out_data        (chain_data[0])
   );

   // row of rotator cells
   for (genvar i = 0; i < pafk_pkg::NUM_CELLS; i++) begin : g_cell
      pafk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .stage_index (pafk_pkg::SHIFT_W'(i)),
         .in_valid    (chain_valid[i]),
         .in_ready    (chain_ready[i]),
         .in_data     (chain_data[i]),
         .out_valid   (chain_valid[i+1]),
         .out_ready   (chain_ready[i+1]),
         .out_data    (chain_data[i+1])
      );
   end

   // position accumulation and result register
   pafk_back u_back (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (chain_valid[pafk_pkg::NUM_CELLS]),
      .in_ready            (chain_ready[pafk_pkg::NUM_CELLS]),
      .in_data             (chain_data[pafk_pkg::NUM_CELLS]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_link_number     (rsp_link_number),
      .rsp_is_end_effector (rsp_is_end_effector)
   );

endmodule

// ----- design/pafk_front.sv -----
// input side: joint angle accumulation, link numbering, gain-corrected
// start vector and quadrant fold; uses pafk_pkg
`timescale 1ns / 1ps

module pafk_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pafk_pkg::LEN_W-1:0]   req_seg_length,
   input  logic [pafk_pkg::ANGLE_W-1:0] req_joint_angle,
   input  logic                         req_last_link,
   output logic                         out_valid,
   input  logic                         out_ready,
   output pafk_pkg::cordic_type         out_data
);

   // arm state
   logic [pafk_pkg::ANGLE_W-1:0] angle_sum_ff, angle_sum_in;
   logic [pafk_pkg::LINK_W-1:0]  link_count_ff, link_count_in;

   // first slot: accepted link with absolute angle
   logic                         a_valid_ff;
   logic [pafk_pkg::LEN_W-1:0]   a_len_ff;
   logic [pafk_pkg::ANGLE_W-1:0] a_angle_ff;
   logic [pafk_pkg::LINK_W-1:0]  a_num_ff;
   logic                         a_last_ff;

   // second slot: start vector and residual angle
   logic                 b_valid_ff;
   pafk_pkg::cordic_type b_data_ff, b_data_in;

   logic a_ready, b_ready, req_take, a_move;
   logic [pafk_pkg::ANGLE_W-1:0] angle_new;

   logic [pafk_pkg::PROD_W-1:0]  prod;
   logic [31:0]                  x_start;
   logic                         flip;
   logic [pafk_pkg::ANGLE_W-1:0] angle_fold;

   // slot handshakes, bubbles collapse
   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_move    = a_valid_ff && b_ready;
   assign req_ready = a_ready;
   assign req_take  = req_valid && a_ready;

   // running angle and link index
   always_comb begin
      angle_new     = angle_sum_ff + req_joint_angle;
      angle_sum_in  = angle_sum_ff;
      link_count_in = link_count_ff;
      if (req_take) begin
         if (req_last_link) begin
            angle_sum_in  = '0;
            link_count_in = '0;
         end else begin
            angle_sum_in = angle_new;
            if (link_count_ff < pafk_pkg::LINK_LAST) begin
               link_count_in = link_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_sum_ff  <= '0;
         link_count_ff <= '0;
      end else begin
         angle_sum_ff  <= angle_sum_in;
         link_count_ff <= link_count_in;
      end
   end

   // first slot
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_len_ff   <= req_seg_length;
         a_angle_ff <= angle_new;
         a_num_ff   <= link_count_ff;
         a_last_ff  <= req_last_link;
      end
   end

   // start vector with gain removed, folded into the right half plane
   always_comb begin
      prod       = pafk_pkg::PROD_W'(a_len_ff) * pafk_pkg::PROD_W'(pafk_pkg::INV_GAIN)
                   + pafk_pkg::PROD_ROUND;
      x_start    = prod[pafk_pkg::PROD_W-1:pafk_pkg::FRAC_DROP];
      flip       = (a_angle_ff >= pafk_pkg::ANGLE_QUARTER)
                   && (a_angle_ff < pafk_pkg::ANGLE_3QUART);
      angle_fold = flip ? (a_angle_ff + pafk_pkg::ANGLE_HALF) : a_angle_ff;

      b_data_in.x = flip ? -$signed(pafk_pkg::DATA_W'(x_start))
                         : $signed(pafk_pkg::DATA_W'(x_start));
      b_data_in.y = '0;
      b_data_in.z = {{(pafk_pkg::DATA_W-pafk_pkg::ANGLE_W-16){angle_fold[pafk_pkg::ANGLE_W-1]}},
                     angle_fold, 16'b0};
      b_data_in.link_num = a_num_ff;
      b_data_in.last     = a_last_ff;
   end

   // second slot
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ----- design/pafk_cell.sv -----
// one rotator cell: a single shift-add micro-rotation with its own
// pipeline slot; uses pafk_pkg
`timescale 1ns / 1ps

module pafk_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pafk_pkg::SHIFT_W-1:0]  stage_index,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  pafk_pkg::cordic_type          in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pafk_pkg::cordic_type          out_data
);

   logic                 valid_ff;
   pafk_pkg::cordic_type data_ff, data_in;

   logic signed [pafk_pkg::DATA_W-1:0] xs, ys, step;

   // slot handshake
   assign in_ready = !valid_ff || out_ready;

   // micro-rotation toward zero residual
   always_comb begin
      xs      = in_data.x >>> stage_index;
      ys      = in_data.y >>> stage_index;
      step    = pafk_pkg::atan_step(stage_index);
      data_in = in_data;
      if (!in_data.z[pafk_pkg::DATA_W-1]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - step;
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/pafk_back.sv -----
// output side: rounds the rotated link to Q8.8, accumulates the joint
// position with saturation and holds the result register; uses pafk_pkg
`timescale 1ns / 1ps

module pafk_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  pafk_pkg::cordic_type                in_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pafk_pkg::COORD_W-1:0] rsp_point_x,
   output logic signed [pafk_pkg::COORD_W-1:0] rsp_point_y,
   output logic [pafk_pkg::LINK_W-1:0]         rsp_link_number,
   output logic                                rsp_is_end_effector
);

   // joint position
   logic signed [pafk_pkg::COORD_W-1:0] joint_x_ff, joint_x_in;
   logic signed [pafk_pkg::COORD_W-1:0] joint_y_ff, joint_y_in;

   // result register
   logic                                valid_ff;
   logic signed [pafk_pkg::COORD_W-1:0] point_x_ff, point_y_ff;
   logic [pafk_pkg::LINK_W-1:0]         link_num_ff;
   logic                                last_ff;

   logic take;
   logic signed [pafk_pkg::DATA_W-1:0]  x_round, y_round;
   logic signed [pafk_pkg::DELTA_W-1:0] dx, dy;
   logic signed [pafk_pkg::COORD_W:0]   sum_x, sum_y;
   logic signed [pafk_pkg::COORD_W-1:0] new_x, new_y;

   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   // round displacement, add and saturate
   always_comb begin
      x_round = in_data.x + pafk_pkg::DATA_ROUND;
      y_round = in_data.y + pafk_pkg::DATA_ROUND;
      dx      = $signed(x_round[pafk_pkg::DATA_W-1:pafk_pkg::FRAC_DROP]);
      dy      = $signed(y_round[pafk_pkg::DATA_W-1:pafk_pkg::FRAC_DROP]);
      sum_x   = (pafk_pkg::COORD_W+1)'(joint_x_ff) + (pafk_pkg::COORD_W+1)'(dx);
      sum_y   = (pafk_pkg::COORD_W+1)'(joint_y_ff) + (pafk_pkg::COORD_W+1)'(dy);

      if (sum_x[pafk_pkg::COORD_W] != sum_x[pafk_pkg::COORD_W-1]) begin
         new_x = sum_x[pafk_pkg::COORD_W] ? pafk_pkg::COORD_MIN : pafk_pkg::COORD_MAX;
      end else begin
         new_x = sum_x[pafk_pkg::COORD_W-1:0];
      end
      if (sum_y[pafk_pkg::COORD_W] != sum_y[pafk_pkg::COORD_W-1]) begin
         new_y = sum_y[pafk_pkg::COORD_W] ? pafk_pkg::COORD_MIN : pafk_pkg::COORD_MAX;
      end else begin
         new_y = sum_y[pafk_pkg::COORD_W-1:0];
      end

      joint_x_in = joint_x_ff;
      joint_y_in = joint_y_ff;
      if (take) begin
         joint_x_in = in_data.last ? '0 : new_x;
         joint_y_in = in_data.last ? '0 : new_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         joint_x_ff <= '0;
         joint_y_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         joint_x_ff <= joint_x_in;
         joint_y_ff <= joint_y_in;
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         point_x_ff  <= new_x;
         point_y_ff  <= new_y;
         link_num_ff <= in_data.link_num;
         last_ff     <= in_data.last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_point_x         = point_x_ff;
   assign rsp_point_y         = point_y_ff;
   assign rsp_link_number     = link_num_ff;
   assign rsp_is_end_effector = last_ff;

endmodule

// ----- tb/tb.sv -----
// testbench for planar_arm_forward_kinematics: directed table then random arms, each point
// checked against an in-bench arm walker or its table entry; depends on pafk_pkg and the dut
`timescale 1ns / 1ps

module tb;

   // rotator sizing as the block uses it
   localparam int ROT_STAGES    = (pafk_pkg::CORDIC_STAGES < 24) ? pafk_pkg::CORDIC_STAGES : 24;
   localparam int SETTLE_CYCLES = ROT_STAGES + 12;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int DIRECTED_ROWS = 20;
   localparam longint unsigned RECIP_GAIN = 64'd2608131496;

   // kinds of random arm
   typedef enum int {ARM_SHORT, ARM_HOLD, ARM_STRETCH, ARM_NOISE} arm_kind_type;

   typedef struct packed {
      logic signed [pafk_pkg::COORD_W-1:0] x;
      logic signed [pafk_pkg::COORD_W-1:0] y;
      logic [pafk_pkg::LINK_W-1:0]         link;
      logic                                tip;
   } point_type;

   typedef struct packed {
      logic [pafk_pkg::LEN_W-1:0]   len;
      logic [pafk_pkg::ANGLE_W-1:0] ang;
      logic                         last;
      logic                         typed;
      point_type                    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [pafk_pkg::LEN_W-1:0] req_seg_length = '0;
   logic [pafk_pkg::ANGLE_W-1:0] req_joint_angle = '0;
   logic req_last_link = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [pafk_pkg::COORD_W-1:0] rsp_point_x;
   logic signed [pafk_pkg::COORD_W-1:0] rsp_point_y;
   logic [pafk_pkg::LINK_W-1:0] rsp_link_number;
   logic rsp_is_end_effector;

   // arm walker state
   logic [pafk_pkg::ANGLE_W-1:0] arm_angle = '0;
   logic signed [pafk_pkg::COORD_W-1:0] arm_x = '0;
   logic signed [pafk_pkg::COORD_W-1:0] arm_y = '0;
   logic [pafk_pkg::LINK_W-1:0] arm_link = '0;

   point_type pending_points [$];
   int mismatch_count = 0;
   int sent_count = 0;
   int idle_cycles = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   logic drv_typed = 1'b0;
   point_type drv_want = '0;

   // arctangent steps in 2^-32 turn
   longint atan_turn [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   // directed rows: zero-length rows carry their point, the rest go to the walker
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{16'h0000, 16'h0000, 1'b0, 1'b1, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h0000, 16'hFFFF, 1'b0, 1'b1, '{22'sd0, 22'sd0, 6'd1, 1'b0}},
      '{16'h0000, 16'h8000, 1'b1, 1'b1, '{22'sd0, 22'sd0, 6'd2, 1'b1}},
      '{16'hFFFF, 16'h0000, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'h3FFF, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'h4000, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'h7FFF, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'h8000, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'hBFFF, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'hC000, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h0001, 16'h2000, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h8000, 16'hE000, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hAAAA, 16'h5555, 1'b0, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h0100, 16'h8001, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{22'sd0, 22'sd0, 6'd0, 1'b1}},
      '{16'h7FFF, 16'h0001, 1'b0, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}},
      '{16'h0080, 16'h7FFF, 1'b1, 1'b0, '{22'sd0, 22'sd0, 6'd0, 1'b0}}
   };

   planar_arm_forward_kinematics u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_seg_length      (req_seg_length),
      .req_joint_angle     (req_joint_angle),
      .req_last_link       (req_last_link),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_link_number     (rsp_link_number),
      .rsp_is_end_effector (rsp_is_end_effector)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // rotate (len, 0) by the absolute angle, gain removed up front
   function automatic void rotate_length(input logic [pafk_pkg::LEN_W-1:0] len,
                                         input logic [pafk_pkg::ANGLE_W-1:0] abs_angle,
                                         output longint dx, output longint dy);
      longint unsigned prod;
      longint x, y, z, xs, ys;
      logic [pafk_pkg::ANGLE_W-1:0] a;
      logic signed [pafk_pkg::ANGLE_W-1:0] t;
      prod = longint'(len) * RECIP_GAIN + 64'd32768;
      x = longint'(prod >> 16);
      y = 0;
      a = abs_angle;
      // fold the left half plane onto the right one
      if (a >= pafk_pkg::ANGLE_QUARTER && a < pafk_pkg::ANGLE_3QUART) begin
         x = -x;
         a = a + pafk_pkg::ANGLE_HALF;
      end
      t = a;
      z = longint'(t) * 65536;
      for (int i = 0; i < ROT_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_turn[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_turn[i];
         end
      end
      dx = (x + 32768) >>> 16;
      dy = (y + 32768) >>> 16;
   endfunction

   function automatic logic signed [pafk_pkg::COORD_W-1:0] clamp_coord(input longint v);
      if (v > longint'(pafk_pkg::COORD_MAX))
         return pafk_pkg::COORD_MAX;
      if (v < longint'(pafk_pkg::COORD_MIN))
         return pafk_pkg::COORD_MIN;
      return pafk_pkg::COORD_W'(v);
   endfunction

   // walk one link of the arm and return the joint it lands on
   function automatic point_type advance_arm(input logic [pafk_pkg::LEN_W-1:0] len,
                                             input logic [pafk_pkg::ANGLE_W-1:0] ang,
                                             input logic last);
      point_type pt;
      longint dx, dy;
      arm_angle = arm_angle + ang;
      rotate_length(len, arm_angle, dx, dy);
      arm_x = clamp_coord(longint'(arm_x) + dx);
      arm_y = clamp_coord(longint'(arm_y) + dy);
      pt.x = arm_x;
      pt.y = arm_y;
      pt.link = arm_link;
      pt.tip = last;
      if (arm_link < pafk_pkg::LINK_LAST)
         arm_link = arm_link + 1'b1;
      // end effector reached: next arm starts at the origin
      if (last) begin
         arm_angle = '0;
         arm_x = '0;
         arm_y = '0;
         arm_link = '0;
      end
      return pt;
   endfunction

   // idle draw, with occasional switches into and out of back-to-back stretches
   function automatic int next_gap(inout bit calm);
      if ($urandom_range(0, 39) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // one link transaction on the request channel
   task automatic drive_link(input logic [pafk_pkg::LEN_W-1:0] len,
                             input logic [pafk_pkg::ANGLE_W-1:0] ang,
                             input logic last, input logic typed, input point_type want);
      int gap;
      gap = next_gap(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_seg_length <= len;
      req_joint_angle <= ang;
      req_last_link <= last;
      drv_typed <= typed;
      drv_want <= want;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // hold the sender until every pending point has come back
   task automatic wait_all_points();
      park_sender();
      while (pending_points.size() != 0)
         @(posedge clock);
   endtask

   // one random arm of the chosen kind
   task automatic send_arm(input arm_kind_type kind);
      int n;
      logic [pafk_pkg::LEN_W-1:0] len;
      logic [pafk_pkg::ANGLE_W-1:0] ang;
      case (kind)
         ARM_SHORT: n = $urandom_range(1, 8);
         ARM_HOLD: n = $urandom_range(16, 24);
         ARM_STRETCH: n = $urandom_range(33, 44);
         default: n = 1;
      endcase
      for (int k = 0; k < n; k++) begin
         len = pafk_pkg::LEN_W'($urandom);
         ang = pafk_pkg::ANGLE_W'($urandom);
         if (kind == ARM_HOLD)
            len = pafk_pkg::LEN_W'($urandom_range(0, 4095));
         // nearly straight arm along an axis, long enough to saturate
         if (kind == ARM_STRETCH) begin
            len = 16'hFF00 | pafk_pkg::LEN_W'($urandom_range(0, 255));
            ang = pafk_pkg::ANGLE_W'($urandom_range(0, 6)) - 16'd3;
            if (k == 0)
               ang = ang + (pafk_pkg::ANGLE_W'($urandom_range(0, 3)) << 14);
         end
         if (kind == ARM_NOISE)
            drive_link(len, ang, 1'($urandom_range(0, 1)), 1'b0, '0);
         else
            drive_link(len, ang, k == n - 1, 1'b0, '0);
      end
   endtask

   // accepted links feed the walker, returned points are checked in order
   always @(posedge clock) begin
      point_type want;
      point_type walked;
      if (!reset && req_valid && req_ready) begin
         walked = advance_arm(req_seg_length, req_joint_angle, req_last_link);
         pending_points.push_back(drv_typed ? drv_want : walked);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("point with nothing pending, link_number",
                            rsp_link_number, -1);
         end else begin
            want = pending_points.pop_front();
            if (rsp_point_x !== want.x)
               report_mismatch("point_x", rsp_point_x, want.x);
            if (rsp_point_y !== want.y)
               report_mismatch("point_y", rsp_point_y, want.y);
            if (rsp_link_number !== want.link)
               report_mismatch("link_number", rsp_link_number, want.link);
            if (rsp_is_end_effector !== want.tip)
               report_mismatch("is_end_effector", rsp_is_end_effector, want.tip);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("** planar_arm_forward_kinematics: FAILED **");
         $finish;
      end
   end

   // result side: random stalls before each transaction
   initial begin
      int gap;
      forever begin
         gap = next_gap(recv_calm);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
      end
   end

   // main sequence
   initial begin
      int pick;
      bit drained_mid;
      drained_mid = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++)
         drive_link(directed_rows[r].len, directed_rows[r].ang, directed_rows[r].last,
                    directed_rows[r].typed, directed_rows[r].want);
      wait_all_points();

      // random arms, mostly well formed
      while (sent_count < RANDOM_ITEMS + DIRECTED_ROWS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_arm(ARM_SHORT);
         else if (pick < 70)
            send_arm(ARM_HOLD);
         else if (pick < 82)
            send_arm(ARM_STRETCH);
         else
            send_arm(ARM_NOISE);
         if (!drained_mid && sent_count > RANDOM_ITEMS / 2) begin
            drained_mid = 1'b1;
            wait_all_points();
         end
      end

      // drain and let the pipeline settle
      wait_all_points();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** planar_arm_forward_kinematics: PASSED **");
      else
         $display("** planar_arm_forward_kinematics: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
design/pafk_pkg.sv
design/pafk_front.sv
design/pafk_cell.sv
design/pafk_back.sv
design/planar_arm_forward_kinematics.sv
tb/tb.sv
